@@ hw/rtl/khbi_pkg.sv @@
package khbi_pkg;

  localparam int unsigned HashW   = 32;
  localparam int unsigned BucketW = 16;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned PaddrW  = 3;
  localparam int unsigned PdataW  = 32;
  localparam int unsigned DivSteps = HashW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  localparam logic [BucketW-1:0] BucketCountReset = BucketW'(100);

  typedef enum logic [0:0] {
    REG_BUCKET_COUNT = 1'b0
  } reg_idx_e;

  typedef struct packed {
    logic [ByteW-1:0] key_byte;
    logic             has_byte;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic [HashW-1:0]   hash_value;
    logic [BucketW-1:0] bucket_index;
  } out_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MIX  = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } back_state_e;

  function automatic logic [HashW-1:0] fold_byte(input logic [HashW-1:0] h,
                                                 input logic [ByteW-1:0] b);
    logic [HashW-1:0] t;
    t = h + HashW'(b);
    t = t + (t << 10);
    t = t ^ (t >> 6);
    return t;
  endfunction

  function automatic logic [HashW-1:0] final_mix(input logic [HashW-1:0] h);
    logic [HashW-1:0] t;
    t = h + (h << 3);
    t = t ^ (t >> 11);
    t = t + (t << 15);
    return t;
  endfunction

endpackage

@@ hw/rtl/khbi_front.sv @@
module khbi_front
  import khbi_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  in_item_t               in_item_i,
  input  fifo_stat_t             fifo_stat_i,
  output logic                   push_o,
  output logic [HashW-1:0]       push_data_o
);

  logic [HashW-1:0] running_hash_q, running_hash_d;
  logic [HashW-1:0] folded;
  logic             accept;

  assign in_ready_o = !fifo_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    folded = in_item_i.has_byte ? fold_byte(running_hash_q, in_item_i.key_byte)
                                : running_hash_q;
  end

  // A key end hands the folded value on and restarts the running hash.
  always_comb begin
    running_hash_d = running_hash_q;
    if (accept) begin
      running_hash_d = in_item_i.last ? '0 : folded;
    end
  end

  assign push_o      = accept && in_item_i.last;
  assign push_data_o = folded;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_hash_q <= '0;
    end else begin
      running_hash_q <= running_hash_d;
    end
  end

endmodule

@@ hw/rtl/khbi_fifo.sv @@
module khbi_fifo
  import khbi_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [HashW-1:0] push_data_i,
  input  logic             pop_i,
  output logic [HashW-1:0] pop_data_o,
  output fifo_stat_t       stat_o
);

  logic [HashW-1:0] mem [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;
  logic [HashW-1:0] rd_data_q;

  assign stat_o.full  = (count_q == 2'd2);
  assign stat_o.empty = (count_q == 2'd0);
  assign pop_data_o   = rd_data_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= push_data_i;
    end
    if (pop_i) begin
      rd_data_q <= mem[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

@@ hw/rtl/khbi_back.sv @@
module khbi_back
  import khbi_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [BucketW-1:0] bucket_count_i,
  input  fifo_stat_t         fifo_stat_i,
  output logic               pop_o,
  input  logic [HashW-1:0]   pop_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_item_o
);

  back_state_e        state_q, state_d;
  logic [HashW-1:0]   hash_q;
  logic [HashW-1:0]   dividend_q;
  logic [BucketW-1:0] rem_q;
  logic [DivCntW-1:0] cnt_q;
  logic               out_valid_q;
  out_item_t          out_item_q;
  logic [BucketW:0]   rem_shift;
  logic [BucketW:0]   rem_next;
  logic               load_out;
  logic [HashW-1:0]   mixed;

  assign pop_o = (state_q == S_IDLE) && !fifo_stat_i.empty;
  assign mixed = final_mix(pop_data_i);

  // One restoring step per cycle, quotient bits are not kept.
  always_comb begin
    rem_shift = {rem_q, dividend_q[HashW-1]};
    rem_next  = rem_shift;
    if (rem_shift >= {1'b0, bucket_count_i}) begin
      rem_next = rem_shift - {1'b0, bucket_count_i};
    end
  end

  assign load_out = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (pop_o) state_d = S_MIX;
      S_MIX:  state_d = S_DIV;
      S_DIV:  if (cnt_q == DivCntW'(DivSteps - 1)) state_d = S_DONE;
      S_DONE: if (load_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_MIX: begin
        hash_q     <= mixed;
        dividend_q <= mixed;
        rem_q      <= '0;
      end
      S_DIV: begin
        dividend_q <= dividend_q << 1;
        rem_q      <= rem_next[BucketW-1:0];
      end
      default: ;
    endcase
    if (load_out) begin
      out_item_q.hash_value   <= hash_q;
      out_item_q.bucket_index <= (bucket_count_i == '0) ? '0 : rem_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_MIX) begin
        cnt_q <= '0;
      end else if (state_q == S_DIV) begin
        cnt_q <= cnt_q + DivCntW'(1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ hw/rtl/key_hash_bucket_index.sv @@
// Streaming one-at-a-time key hash with bucket reduction. Key bytes enter one
// item per cycle; the front folds each byte into the running hash in the same
// cycle it is accepted. An item with last set closes the key and passes the
// folded value through a two-entry queue to the back, which pops it, applies the
// final mix, reduces it modulo bucket_count with a bit-serial remainder unit (one
// dividend bit per cycle) and loads the output register, waiting while the previous
// result waits, so each key end occupies the back until its result is loaded.
// Items keep flowing at one per cycle while the back works, until two key ends
// wait in the queue; then the input stalls, byte items included, until the back
// pops one. bucket_count of zero gives bucket_index 0.
// bucket_count is register 0 at APB byte address 0 and resets to 100.
module key_hash_bucket_index
  import khbi_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_item_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  logic [BucketW-1:0] bucket_count_q;
  logic               push;
  logic [HashW-1:0]   push_data;
  logic               pop;
  logic [HashW-1:0]   pop_data;
  fifo_stat_t         fifo_stat;
  logic               reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[PaddrW-1:2] == REG_BUCKET_COUNT);
  assign prdata  = reg_sel ? PdataW'(bucket_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= BucketCountReset;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      bucket_count_q <= pwdata[BucketW-1:0];
    end
  end

  khbi_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  khbi_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (fifo_stat)
  );

  khbi_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .bucket_count_i (bucket_count_q),
    .fifo_stat_i    (fifo_stat),
    .pop_o          (pop),
    .pop_data_i     (pop_data),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_item_o     (out_item_o)
  );

  // A key end always leaves something queued for the back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> !fifo_stat.empty)
    else $error("queue empty after key end");

  // Never push into a full queue, not even in a cycle that pops.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_stat.full |-> !push)
    else $error("push into full queue");

  // A new result appears only after the remainder unit has finished.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o)) |-> $past(u_back.state_q == S_DONE))
    else $error("result without finished reduction");

endmodule

@@ test/tb.sv @@
module tb;
  import khbi_pkg::*;

  localparam int unsigned CycleLimit   = 300000;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned ItemsPerRun  = 170;
  localparam int unsigned MaxReports   = 10;
  localparam logic [15:0] ResetBuckets = 16'd100;
  localparam logic [1:0]  RegBucket    = 2'(REG_BUCKET_COUNT);
  localparam logic [1:0]  RegUnmapped  = 2'd1;

  typedef enum logic [0:0] {
    ROW_KEY,
    ROW_REG
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  reg_no;
    logic [15:0] wdata;
    logic [7:0]  key_byte;
    logic        has_byte;
    logic        last;
    logic        typed;
    logic [31:0] want_hash;
    logic [15:0] want_idx;
  } script_row_t;

  localparam int unsigned NRows = 22;

  // kind, register, value, byte, has_byte, last, typed, hash, index
  localparam script_row_t Script [NRows] = '{
    '{ROW_KEY, RegBucket,   16'h0000, 8'h00, 1'b0, 1'b1, 1'b1, 32'h0, 16'h0},
    '{ROW_KEY, RegBucket,   16'h0000, 8'h00, 1'b1, 1'b1, 1'b1, 32'h0, 16'h0},
    '{ROW_KEY, RegBucket,   16'h0000, 8'hA5, 1'b0, 1'b0, 1'b0, 32'h0, 16'h0},
    '{ROW_KEY, RegBucket,   16'h0000, 8'hFF, 1'b1, 1'b0, 1'b0, 32'h0, 16'h0},
    '{ROW_KEY, RegBucket,   16'h0000, 8'h00, 1'b1, 1'b0, 1'b0, 32'h0, 16'h0},
    '{ROW_KEY, RegBucket,   16'h0000, 8'h5A, 1'b0, 1'b0, 1'b0, 32'h0, 16'h0},
    '{ROW_KEY, RegBucket,   16'h0000, 8'h80, 1'b1, 1'b1, 1'b0, 32'h0, 16'h0},
    '{ROW_KEY, RegBucket,   16'h0000, 8'h01, 1'b1, 1'b0, 1'b0, 32'h0, 16'h0},
    '{ROW_KEY, RegBucket,   16'h0000, 8'h7F, 1'b1, 1'b0, 1'b0, 32'h0, 16'h0},
    '{ROW_KEY, RegBucket,   16'h0000, 8'hFF, 1'b0, 1'b1, 1'b0, 32'h0, 16'h0},
    '{ROW_REG, RegBucket,   16'h0001, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0, 16'h0},
    '{ROW_KEY, RegBucket,   16'h0000, 8'hFF, 1'b1, 1'b1, 1'b0, 32'h0, 16'h0},
    '{ROW_REG, RegBucket,   16'hFFFF, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0, 16'h0},
    '{ROW_KEY, RegBucket,   16'h0000, 8'hC3, 1'b1, 1'b0, 1'b0, 32'h0, 16'h0},
    '{ROW_KEY, RegBucket,   16'h0000, 8'h3C, 1'b1, 1'b1, 1'b0, 32'h0, 16'h0},
    '{ROW_REG, RegBucket,   16'h0000, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0, 16'h0},
    '{ROW_KEY, RegBucket,   16'h0000, 8'h55, 1'b1, 1'b1, 1'b0, 32'h0, 16'h0},
    '{ROW_KEY, RegBucket,   16'h0000, 8'h00, 1'b0, 1'b1, 1'b1, 32'h0, 16'h0},
    '{ROW_REG, RegUnmapped, 16'h0005, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0, 16'h0},
    '{ROW_KEY, RegBucket,   16'h0000, 8'hAA, 1'b1, 1'b1, 1'b0, 32'h0, 16'h0},
    '{ROW_REG, RegBucket,   16'h0064, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0, 16'h0},
    '{ROW_KEY, RegBucket,   16'h0000, 8'h00, 1'b0, 1'b1, 1'b1, 32'h0, 16'h0}
  };

  localparam logic [15:0] BucketSweep [9] = '{
    16'd1, 16'hFFFF, 16'd0, 16'd2, 16'hFFFE, 16'd255, 16'd4096, 16'd37, 16'd1000
  };

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  in_item_t          in_item_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  out_item_t         out_item_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [PaddrW-1:0] paddr       = '0;
  logic [PdataW-1:0] pwdata      = '0;
  logic [PdataW-1:0] prdata;
  logic              pready;

  logic [31:0] run_hash   = '0;
  logic [15:0] bucket_cnt = ResetBuckets;
  out_item_t   pending_hashes[$];

  int unsigned n_cycles    = 0;
  int unsigned n_errors    = 0;
  int unsigned n_items     = 0;
  int unsigned n_results   = 0;
  int unsigned n_settings  = 0;
  int unsigned hold_cycles = 0;
  bit          tx_calm     = 1'b0;
  bit          rx_calm     = 1'b0;

  key_hash_bucket_index i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_item_i,
    .out_valid_o,
    .out_ready_i,
    .out_item_o,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d hashes still pending", n_cycles,
               pending_hashes.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  function automatic logic [31:0] oaat_step(logic [31:0] h, logic [7:0] b);
    logic [31:0] t;
    t = h + {24'd0, b};
    t = t + (t << 10);
    return t ^ (t >> 6);
  endfunction

  function automatic logic [31:0] oaat_finish(logic [31:0] h);
    logic [31:0] t;
    t = h + (h << 3);
    t = t ^ (t >> 11);
    return t + (t << 15);
  endfunction

  function automatic void note_error(string what, logic [63:0] want, logic [63:0] got);
    n_errors++;
    if (n_errors <= MaxReports)
      $display("mismatch on %s at cycle %0d: expected %0h, got %0h", what, n_cycles, want,
               got);
  endfunction

  // Fold the item into the running hash; on a key end queue the expected result (the row's own if typed).
  function automatic void hash_key_item(in_item_t it, bit typed, out_item_t want);
    out_item_t res;
    if (it.has_byte) run_hash = oaat_step(run_hash, it.key_byte);
    if (it.last) begin
      res.hash_value   = oaat_finish(run_hash);
      res.bucket_index = (bucket_cnt == '0) ? '0 : 16'(res.hash_value % bucket_cnt);
      run_hash = '0;
      pending_hashes.push_back(typed ? want : res);
    end
  endfunction

  function automatic void check_hash(out_item_t got);
    out_item_t want;
    n_results++;
    if (pending_hashes.size() == 0) begin
      note_error("unexpected result", '0, got);
      return;
    end
    want = pending_hashes.pop_front();
    if (got.hash_value !== want.hash_value)
      note_error("hash_value", want.hash_value, got.hash_value);
    if (got.bucket_index !== want.bucket_index)
      note_error("bucket_index", want.bucket_index, got.bucket_index);
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    int unsigned gap;
    if ($urandom_range(0, 49) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    if (it.has_byte || it.last) n_items++;
    hash_key_item(it, typed, want);
  endtask

  // Key of random length; it closes either on its last byte or with an empty end item.
  task automatic send_random_key();
    int unsigned len;
    bit          byte_on_end;
    in_item_t    it;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
    byte_on_end = (len != 0) && ($urandom_range(0, 1) == 1);
    for (int unsigned k = 0; k < len; k++) begin
      if ($urandom_range(0, 11) == 0) begin
        it = '{key_byte: 8'($urandom), has_byte: 1'b0, last: 1'b0};
        send_item(it, 1'b0, '0);
      end
      it = '{key_byte: pick_byte(), has_byte: 1'b1, last: byte_on_end && (k == len - 1)};
      send_item(it, 1'b0, '0);
    end
    if (!byte_on_end) begin
      it = '{key_byte: 8'($urandom), has_byte: 1'b0, last: 1'b1};
      send_item(it, 1'b0, '0);
    end
  endtask

  // Hold the input low until every hash is out, then let the back end settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PaddrW'({idx, 2'b00});
    pwdata  <= PdataW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == RegBucket) bucket_cnt = val;
  endtask

  task automatic apb_read(logic [1:0] idx, output logic [PdataW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= PaddrW'({idx, 2'b00});
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    val = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_register(logic [1:0] idx, logic [15:0] val);
    logic [PdataW-1:0] rd;
    apb_write(idx, val);
    if (idx == RegBucket) begin
      n_settings++;
      apb_read(idx, rd);
      if (rd[15:0] !== bucket_cnt) note_error("bucket_count readback", bucket_cnt, rd);
    end
  endtask

  // Result side: random stalls, calm stretches, and a long hold on request.
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      if (hold_cycles != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
      stall = rx_calm ? 0 : $urandom_range(0, 6);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o && hold_cycles == 0) @(posedge clk_i);
      if (out_valid_o) check_hash(out_item_o);
    end
  end

  initial begin
    in_item_t    it;
    out_item_t   want;
    int unsigned start;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < NRows; r++) begin
      if (Script[r].kind == ROW_REG) begin
        drain();
        set_register(Script[r].reg_no, Script[r].wdata);
      end else begin
        it   = '{key_byte: Script[r].key_byte, has_byte: Script[r].has_byte,
                 last: Script[r].last};
        want = '{hash_value: Script[r].want_hash, bucket_index: Script[r].want_idx};
        send_item(it, Script[r].typed, want);
      end
    end

    for (int p = 0; p < 10; p++) begin
      drain();
      set_register(RegBucket, (p < 9) ? BucketSweep[p] : 16'($urandom_range(1, 65535)));
      start = n_items;
      while (n_items - start < ItemsPerRun) send_random_key();
    end

    // Stall the result side for a long stretch while key ends keep coming.
    drain();
    tx_calm     = 1'b1;
    hold_cycles = 400;
    repeat (30) begin
      it = '{key_byte: 8'($urandom), has_byte: 1'($urandom), last: 1'b1};
      send_item(it, 1'b0, '0);
    end
    drain();

    if (pending_hashes.size() != 0) note_error("hashes left over", 0, pending_hashes.size());
    $display("sent %0d key items, checked %0d hashes over %0d bucket count settings",
             n_items, n_results, n_settings);
    $display("random stalls on both sides, one 400-cycle output hold, %0d mismatches",
             n_errors);
    if (n_errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/khbi_pkg.sv
hw/rtl/khbi_front.sv
hw/rtl/khbi_fifo.sv
hw/rtl/khbi_back.sv
hw/rtl/key_hash_bucket_index.sv
test/tb.sv
